@@ hw/rtl/mtd_pkg.sv @@
// ----------------------------------------------------------------------------
// Meter time decomposer package
// Shared constants, item formats and helpers for the meter time decomposer.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int MAX_CHANGES_DEF = 64;
    localparam int TIME_BITS_DEF   = 32;

    localparam int FIELD_TIME_W = 32;
    localparam int DUR_W        = 24;
    localparam int SLOT_W       = 6;
    localparam int CFG_W        = 7;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                           kind;
        logic [SLOT_W-1:0]              entry_index;
        logic signed [FIELD_TIME_W-1:0] change_time;
        logic [DUR_W-1:0]               bar_length;
        logic [DUR_W-1:0]               beat_length;
        logic signed [FIELD_TIME_W-1:0] query_time;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]              entry_used;
        logic signed [FIELD_TIME_W-1:0] bar_count;
        logic signed [FIELD_TIME_W-1:0] bar_start;
        logic [DUR_W-1:0]               beat_in_bar;
        logic [DUR_W-1:0]               tick_in_beat;
        logic [DUR_W-1:0]               offset_in_bar;
    } result_item_t;

    // A duration of zero is treated as one tick.
    function automatic logic [DUR_W-1:0] dur_fix(input logic [DUR_W-1:0] v);
        return (v == '0) ? DUR_W'(1) : v;
    endfunction

endpackage

@@ hw/rtl/mtd_ifs.sv @@
// ----------------------------------------------------------------------------
// Meter time decomposer channels
// Valid/ready channels for items, results and the configuration register.
// ----------------------------------------------------------------------------
interface mtd_in_if;
    logic               valid;
    logic               ready;
    mtd_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mtd_out_if;
    logic                  valid;
    logic                  ready;
    mtd_pkg::result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mtd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mtd_pkg::CFG_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/mtd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mtd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/meter_time_decomposer_core.sv @@
// ----------------------------------------------------------------------------
// Meter time decomposer core
// Splits a tick time into bars, beats and ticks over a table of meter changes.
// ----------------------------------------------------------------------------
// Items arrive on in_ch. A load item writes one table entry in the transfer
// cycle and gives no result; the block is ready again in the next cycle.
// A query item walks the table from entry 0 and returns one result on out_ch.
// All division is done by one restoring divider, one quotient bit per cycle,
// over TIME_BITS + 2 bits; in_ch is not ready while a query is in progress.
// The result waits in an output register, so the next item is taken while a
// result is still held. If the receiver stalls with a result held, a finished
// query waits until that register is free.
// cfg_ch is always ready and sets how many entries are in use; the user must
// write it only while no query is in progress, as the block does not enforce
// this. Reset sets it to one, empties the output register and returns to
// idle; table contents are kept undefined until loaded.
// ----------------------------------------------------------------------------
module meter_time_decomposer_core #(
    parameter int MAX_CHANGES = mtd_pkg::MAX_CHANGES_DEF,
    parameter int TIME_BITS   = mtd_pkg::TIME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mtd_in_if.sink       in_ch,
    mtd_out_if.source    out_ch,
    mtd_cfg_if.sink      cfg_ch
);

    localparam int DUR_W  = mtd_pkg::DUR_W;
    localparam int CFG_W  = mtd_pkg::CFG_W;
    localparam int SLOT_W = mtd_pkg::SLOT_W;
    localparam int OUT_W  = mtd_pkg::FIELD_TIME_W;
    localparam int IDX_W  = $clog2(MAX_CHANGES);
    localparam int N_W    = $clog2(MAX_CHANGES + 1);
    localparam int W      = TIME_BITS + 2;
    localparam int CNT_W  = $clog2(W);
    localparam int RAM_W  = TIME_BITS + 2 * DUR_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CUR    = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;
    localparam logic [2:0] S_ISSUE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam logic [1:0] MODE_WALK = 2'd0;
    localparam logic [1:0] MODE_BAR  = 2'd1;
    localparam logic [1:0] MODE_BEAT = 2'd2;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [CFG_W-1:0]            cfg_n_reg;
    logic                        out_valid_reg;
    mtd_pkg::result_item_t       out_data_reg;

    logic [IDX_W-1:0]            i_reg;
    logic signed [TIME_BITS-1:0] q_reg;
    logic signed [TIME_BITS-1:0] nxt_time_reg;
    logic [DUR_W-1:0]            nxt_bar_reg;
    logic [DUR_W-1:0]            nxt_beat_reg;
    logic [DUR_W-1:0]            cur_bar_reg;
    logic [DUR_W-1:0]            cur_beat_reg;
    logic signed [W-1:0]         origin_reg;
    logic signed [OUT_W-1:0]     count_reg;
    logic [DUR_W-1:0]            offset_reg;
    logic [1:0]                  mode_reg;
    logic                        neg_reg;
    logic [W-1:0]                quo_reg;
    logic [DUR_W-1:0]            rem_reg;
    logic [CNT_W-1:0]            cnt_reg;

    logic                        in_xfer;
    logic                        out_free;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [RAM_W-1:0]            ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [RAM_W-1:0]            rd_data;
    logic signed [TIME_BITS-1:0] rd_time;
    logic [DUR_W-1:0]            rd_bar;
    logic [DUR_W-1:0]            rd_beat;

    logic [N_W-1:0]              n_lim;
    logic [IDX_W:0]              i_plus;
    logic                        walk_on;
    logic signed [W-1:0]         span;
    logic [W-1:0]                span_mag;

    logic [DUR_W-1:0]            divisor;
    logic [DUR_W:0]              rem_sh;
    logic                        fits;
    logic [DUR_W-1:0]            rem_step;
    logic [W-1:0]                quo_step;

    logic signed [W-1:0]         rem_s;
    logic signed [W-1:0]         bar_s;
    logic signed [W-1:0]         quo_s;
    logic signed [W-1:0]         c_ext;
    logic signed [W-1:0]         q_ext;
    logic                        rem_zero;
    logic signed [W-1:0]         units;
    logic signed [W-1:0]         origin_post;
    logic [DUR_W-1:0]            offset_bar;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Table storage: start tick, bar length and beat length in one word.
    assign ram_we    = in_xfer && (in_ch.data.kind == mtd_pkg::KIND_LOAD)
                       && (32'(in_ch.data.entry_index) < MAX_CHANGES);
    assign ram_waddr = IDX_W'(in_ch.data.entry_index);
    assign ram_wdata = {TIME_BITS'(in_ch.data.change_time), in_ch.data.bar_length,
                        in_ch.data.beat_length};
    assign ram_raddr = (state_reg == S_IDLE) ? '0 : i_plus[IDX_W-1:0];

    mtd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_CHANGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign rd_time = rd_data[RAM_W-1 -: TIME_BITS];
    assign rd_bar  = rd_data[2*DUR_W-1 -: DUR_W];
    assign rd_beat = rd_data[DUR_W-1:0];

    always_comb
    begin
        if (cfg_n_reg == '0)
        begin
            n_lim = N_W'(1);
        end
        else if (32'(cfg_n_reg) > MAX_CHANGES)
        begin
            n_lim = N_W'(MAX_CHANGES);
        end
        else
        begin
            n_lim = N_W'(cfg_n_reg);
        end
    end

    assign i_plus   = {1'b0, i_reg} + (IDX_W+1)'(1);
    assign walk_on  = (i_plus < (IDX_W+1)'(n_lim)) && (rd_time <= q_reg);
    assign span     = walk_on ? (W'(rd_time) - origin_reg) : (W'(q_reg) - origin_reg);
    assign span_mag = span[W-1] ? W'(-span) : W'(span);

    // Shared restoring divider step.
    assign divisor  = (mode_reg == MODE_BEAT) ? cur_beat_reg : cur_bar_reg;
    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign fits     = (rem_sh >= {1'b0, divisor});
    assign rem_step = fits ? DUR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DUR_W-1:0];
    assign quo_step = {quo_reg[W-2:0], fits};

    // Folding a quotient and remainder back into the bar origin and count.
    assign rem_s    = W'(rem_reg);
    assign bar_s    = W'(cur_bar_reg);
    assign quo_s    = quo_reg;
    assign c_ext    = W'(nxt_time_reg);
    assign q_ext    = W'(q_reg);
    assign rem_zero = (rem_reg == '0);

    always_comb
    begin
        if (mode_reg == MODE_WALK)
        begin
            units       = neg_reg ? -quo_s : quo_s;
            origin_post = neg_reg ? (c_ext + rem_s) : (c_ext - rem_s);
            offset_bar  = rem_reg;
        end
        else if (!neg_reg)
        begin
            units       = quo_s;
            origin_post = q_ext - rem_s;
            offset_bar  = rem_reg;
        end
        else if (rem_zero)
        begin
            units       = -quo_s;
            origin_post = q_ext;
            offset_bar  = '0;
        end
        else
        begin
            units       = ~quo_s;
            origin_post = q_ext + rem_s - bar_s;
            offset_bar  = cur_bar_reg - rem_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_ch.data.kind == mtd_pkg::KIND_QUERY))
                begin
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (mode_reg == MODE_WALK)
                begin
                    state_next = S_ISSUE;
                end
                else if (mode_reg == MODE_BAR)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ISSUE:
            begin
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_n_reg     <= CFG_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                cfg_n_reg <= cfg_ch.data;
            end
            if ((state_reg == S_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_ch.data.kind == mtd_pkg::KIND_QUERY))
                begin
                    q_reg      <= TIME_BITS'(in_ch.data.query_time);
                    i_reg      <= '0;
                    origin_reg <= '0;
                    count_reg  <= '0;
                end
            end
            S_CUR:
            begin
                cur_bar_reg  <= mtd_pkg::dur_fix(rd_bar);
                cur_beat_reg <= mtd_pkg::dur_fix(rd_beat);
            end
            S_CHECK:
            begin
                nxt_time_reg <= rd_time;
                nxt_bar_reg  <= mtd_pkg::dur_fix(rd_bar);
                nxt_beat_reg <= mtd_pkg::dur_fix(rd_beat);
                neg_reg      <= span[W-1];
                quo_reg      <= span_mag;
                rem_reg      <= '0;
                cnt_reg      <= CNT_W'(W - 1);
                mode_reg     <= walk_on ? MODE_WALK : MODE_BAR;
            end
            S_DIV:
            begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            S_POST:
            begin
                if (mode_reg == MODE_WALK)
                begin
                    count_reg    <= count_reg + OUT_W'(units);
                    origin_reg   <= origin_post;
                    i_reg        <= i_plus[IDX_W-1:0];
                    cur_bar_reg  <= nxt_bar_reg;
                    cur_beat_reg <= nxt_beat_reg;
                end
                else if (mode_reg == MODE_BAR)
                begin
                    count_reg  <= count_reg + OUT_W'(units);
                    origin_reg <= origin_post;
                    offset_reg <= offset_bar;
                    neg_reg    <= 1'b0;
                    quo_reg    <= W'(offset_bar);
                    rem_reg    <= '0;
                    cnt_reg    <= CNT_W'(W - 1);
                    mode_reg   <= MODE_BEAT;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_data_reg.entry_used    <= SLOT_W'(i_reg);
                    out_data_reg.bar_count     <= count_reg;
                    out_data_reg.bar_start     <= OUT_W'(origin_reg);
                    out_data_reg.beat_in_bar   <= quo_reg[DUR_W-1:0];
                    out_data_reg.tick_in_beat  <= rem_reg;
                    out_data_reg.offset_in_bar <= offset_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> ({1'b0, i_reg} < (IDX_W+1)'(n_lim)))
        else $error("walk index passed the entries in use");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (divisor != '0))
        else $error("divider started with a zero divisor");

    a_result_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> ((offset_reg < cur_bar_reg)
                                     && (rem_reg < cur_beat_reg)))
        else $error("bar offset or beat remainder out of range");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_ch.data.kind == mtd_pkg::KIND_QUERY)) |=> !in_ch.ready)
        else $error("ready while a query is in progress");
`endif

endmodule
